// ===== design/svm_pkg.sv =====
// ----------------------------------------------------------------------------
// svm_pkg: shared types and constants of the supply voltage monitor
// Word widths, reset values and the digit weight table used by the
// monitor's digit extraction steps.
// ----------------------------------------------------------------------------
package svm_pkg;

  // Field widths
  localparam int NUM_W   = 21;
  localparam int ACC_W   = 27;
  localparam int MV_W    = 14;
  localparam int DIGIT_W = 4;

  // Parameter defaults
  localparam int FILTER_SHIFT_DEF = 6;
  localparam int SAMPLE_BITS_DEF  = 10;

  // Reset values and limits
  localparam logic [NUM_W-1:0] NUM_RESET = NUM_W'(1105920);
  localparam logic [MV_W-1:0]  SHOW_MAX  = MV_W'(9999);
  localparam int               START_MV  = 5000;

  // Digit extraction: three digits, four binary weights each
  localparam int DIG_STEPS = 12;

  typedef logic [MV_W-1:0] mv_t;

  // Weight compared against the residual at each extraction step
  function automatic mv_t digit_weight(input logic [3:0] idx);
    mv_t w;
    case (idx)
      4'd0:    w = MV_W'(8000);
      4'd1:    w = MV_W'(4000);
      4'd2:    w = MV_W'(2000);
      4'd3:    w = MV_W'(1000);
      4'd4:    w = MV_W'(800);
      4'd5:    w = MV_W'(400);
      4'd6:    w = MV_W'(200);
      4'd7:    w = MV_W'(100);
      4'd8:    w = MV_W'(80);
      4'd9:    w = MV_W'(40);
      4'd10:   w = MV_W'(20);
      4'd11:   w = MV_W'(10);
      default: w = '0;
    endcase
    return w;
  endfunction

endpackage

// ===== design/svm_if.sv =====
// ----------------------------------------------------------------------------
// svm_if: channel interfaces of the supply voltage monitor
// Sample channel and result channel, valid/ready handshake.
// ----------------------------------------------------------------------------
interface svm_in_if #(
  parameter int SAMPLE_BITS = svm_pkg::SAMPLE_BITS_DEF
);
  logic                   valid;
  logic                   ready;
  logic [SAMPLE_BITS-1:0] raw_sample;

  modport source (output valid, output raw_sample, input ready);
  modport sink   (input valid, input raw_sample, output ready);
endinterface

interface svm_out_if;
  logic                        valid;
  logic                        ready;
  logic                        divide_error;
  logic [svm_pkg::MV_W-1:0]    supply_mv;
  logic [svm_pkg::DIGIT_W-1:0] volts_digit;
  logic [svm_pkg::DIGIT_W-1:0] tenths_digit;
  logic [svm_pkg::DIGIT_W-1:0] hundredths_digit;

  modport source (output valid, output divide_error, output supply_mv,
                  output volts_digit, output tenths_digit,
                  output hundredths_digit, input ready);
  modport sink   (input valid, input divide_error, input supply_mv,
                  input volts_digit, input tenths_digit,
                  input hundredths_digit, output ready);
endinterface

// ===== design/supply_voltage_monitor.sv =====
// Sequence: sample accept, divide steps, filter update, display load, digit
// steps, result hold; a zero sample skips the divide steps and filter update.
// A new word is accepted only after the result is taken; the single shared
// subtractor, one bit per cycle, sets the pace.
// Reset: filter accumulator to 5000 mV times 2^FILTER_SHIFT, numerator to
// 1105920, sequencer idle, no result pending.
// ----------------------------------------------------------------------------
// supply_voltage_monitor: supply millivolts from a bandgap reading
// Divides the reference numerator by the sample, feeds a leaky accumulator
// and extracts decimal digits; divide and digit steps share one compare-subtract unit.
// ----------------------------------------------------------------------------
module supply_voltage_monitor #(
  parameter int FILTER_SHIFT = svm_pkg::FILTER_SHIFT_DEF,
  parameter int SAMPLE_BITS  = svm_pkg::SAMPLE_BITS_DEF
) (
  input  logic                      clk,
  input  logic                      rst_n,
  svm_in_if.sink                    in_ch,
  svm_out_if.source                 out_ch,
  input  logic                      cfg_wr_en,
  input  logic [svm_pkg::NUM_W-1:0] cfg_wr_data
);
  import svm_pkg::*;

  localparam int SUB_W = (SAMPLE_BITS + 1 > MV_W) ? SAMPLE_BITS + 1 : MV_W;
  localparam int CNT_W = $clog2(NUM_W + 1);
  localparam logic [ACC_W-1:0] ACC_RESET = ACC_W'(START_MV << FILTER_SHIFT);
  localparam logic [ACC_W:0]   ACC_MAX   = {1'b0, {ACC_W{1'b1}}};

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_DIV  = 3'd1;
  localparam logic [2:0] S_UPD  = 3'd2;
  localparam logic [2:0] S_DISP = 3'd3;
  localparam logic [2:0] S_DIG  = 3'd4;
  localparam logic [2:0] S_OUT  = 3'd5;

  // Control state
  logic [2:0]       state_r, state_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [NUM_W-1:0] numer_r, numer_nxt;
  logic [ACC_W-1:0] acc_r, acc_nxt;
  logic             err_r, err_nxt;

  // Working payload
  logic [SAMPLE_BITS-1:0] divisor_r, divisor_nxt;
  logic [NUM_W-1:0]       quot_r, quot_nxt;
  logic [SUB_W-1:0]       work_r, work_nxt;
  logic [DIG_STEPS-1:0]   digits_r, digits_nxt;
  logic [MV_W-1:0]        shown_r, shown_nxt;

  // Shared compare-subtract unit
  logic [SUB_W-1:0] op_a, op_b;
  logic [SUB_W:0]   diff;
  logic             fits;

  logic [SAMPLE_BITS:0] rem_shift;
  logic [ACC_W:0]       acc_sum;
  logic [ACC_W-1:0]     acc_scaled;

  assign rem_shift = {work_r[SAMPLE_BITS-1:0], quot_r[NUM_W-1]};

  always_comb begin
    if (state_r == S_DIV) begin
      op_a = SUB_W'(rem_shift);
      op_b = SUB_W'(divisor_r);
    end else begin
      op_a = work_r;
      op_b = SUB_W'(digit_weight(cnt_r[3:0]));
    end
  end

  assign diff = {1'b0, op_a} - {1'b0, op_b};
  assign fits = ~diff[SUB_W];

  // Leaky accumulator update and display scaling
  assign acc_sum    = {1'b0, acc_r} - {1'b0, acc_r >> FILTER_SHIFT}
                    + (ACC_W + 1)'(quot_r);
  assign acc_scaled = acc_r >> FILTER_SHIFT;

  // Sequencer
  always_comb begin
    state_nxt   = state_r;
    cnt_nxt     = cnt_r;
    numer_nxt   = numer_r;
    acc_nxt     = acc_r;
    err_nxt     = err_r;
    divisor_nxt = divisor_r;
    quot_nxt    = quot_r;
    work_nxt    = work_r;
    digits_nxt  = digits_r;
    shown_nxt   = shown_r;

    if (cfg_wr_en) begin
      numer_nxt = cfg_wr_data;
    end

    case (state_r)
      S_IDLE: begin
        if (in_ch.valid) begin
          divisor_nxt = in_ch.raw_sample;
          quot_nxt    = numer_r;
          work_nxt    = '0;
          cnt_nxt     = CNT_W'(NUM_W - 1);
          err_nxt     = (in_ch.raw_sample == '0);
          state_nxt   = (in_ch.raw_sample == '0) ? S_DISP : S_DIV;
        end
      end
      // One quotient bit per cycle
      S_DIV: begin
        work_nxt = fits ? diff[SUB_W-1:0] : SUB_W'(rem_shift);
        quot_nxt = {quot_r[NUM_W-2:0], fits};
        cnt_nxt  = cnt_r - 1'b1;
        if (cnt_r == '0) begin
          state_nxt = S_UPD;
        end
      end
      // Fold the quotient into the filter, saturating
      S_UPD: begin
        acc_nxt   = (acc_sum > ACC_MAX) ? ACC_MAX[ACC_W-1:0] : acc_sum[ACC_W-1:0];
        state_nxt = S_DISP;
      end
      // Load the saturated display value
      S_DISP: begin
        shown_nxt = (acc_scaled > ACC_W'(SHOW_MAX)) ? SHOW_MAX : MV_W'(acc_scaled);
        work_nxt  = (acc_scaled > ACC_W'(SHOW_MAX)) ? SUB_W'(SHOW_MAX)
                                                    : SUB_W'(acc_scaled);
        cnt_nxt   = '0;
        state_nxt = S_DIG;
      end
      // One binary digit weight per cycle
      S_DIG: begin
        if (fits) begin
          work_nxt = diff[SUB_W-1:0];
        end
        digits_nxt = {digits_r[DIG_STEPS-2:0], fits};
        cnt_nxt    = cnt_r + 1'b1;
        if (cnt_r == CNT_W'(DIG_STEPS - 1)) begin
          state_nxt = S_OUT;
        end
      end
      // Hold the result until taken
      S_OUT: begin
        if (out_ch.ready) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      cnt_r   <= '0;
      numer_r <= NUM_RESET;
      acc_r   <= ACC_RESET;
      err_r   <= 1'b0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      numer_r <= numer_nxt;
      acc_r   <= acc_nxt;
      err_r   <= err_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    divisor_r <= divisor_nxt;
    quot_r    <= quot_nxt;
    work_r    <= work_nxt;
    digits_r  <= digits_nxt;
    shown_r   <= shown_nxt;
  end

  // Channel outputs
  assign in_ch.ready             = (state_r == S_IDLE);
  assign out_ch.valid            = (state_r == S_OUT);
  assign out_ch.divide_error     = err_r;
  assign out_ch.supply_mv        = shown_r;
  assign out_ch.volts_digit      = digits_r[11:8];
  assign out_ch.tenths_digit     = digits_r[7:4];
  assign out_ch.hundredths_digit = digits_r[3:0];

endmodule

// ===== verif/supply_voltage_monitor_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// supply_voltage_monitor_tb: self-checking bench for the supply monitor
// Drives bandgap readings through the sample channel and predicts each
// filtered millivolt word in the bench. The bench changes the reference
// numerator between phases, and both channels stall at random.
// ----------------------------------------------------------------------------
module supply_voltage_monitor_tb;
  import svm_pkg::*;

  localparam int SAMPLE_W  = SAMPLE_BITS_DEF;
  localparam int SHIFT     = FILTER_SHIFT_DEF;
  localparam logic [ACC_W-1:0] ACC_MAX  = {ACC_W{1'b1}};
  localparam logic [NUM_W-1:0] NUM_MAX  = {NUM_W{1'b1}};
  localparam logic [NUM_W-1:0] NUM_ZERO = '0;
  localparam int RANDOM_PHASES   = 5;
  localparam int ITEMS_PER_PHASE = 130;
  localparam int FULL_RATE_PHASE = 2;
  localparam int SETTLE_CYCLES   = 40;

  typedef struct packed {
    logic                 divide_error;
    mv_t                  supply_mv;
    logic [DIGIT_W-1:0]   volts_digit;
    logic [DIGIT_W-1:0]   tenths_digit;
    logic [DIGIT_W-1:0]   hundredths_digit;
  } reading_t;

  typedef struct {
    logic [SAMPLE_W-1:0] sample;
    bit                  typed;
    reading_t            result;
  } stim_row_t;

  logic clk = 1'b0;
  logic rst_n;
  logic cfg_wr_en;
  logic [NUM_W-1:0] cfg_wr_data;

  svm_in_if  in_if ();
  svm_out_if out_if ();

  supply_voltage_monitor dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_ch       (in_if),
    .out_ch      (out_if),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data)
  );

  // Bench copy of the block state
  logic [NUM_W-1:0] numerator;
  logic [ACC_W-1:0] filtered_acc;
  reading_t         pending_readings [$];
  int               fail_count = 0;
  bit               no_idle = 1'b0;

  // Directed readings at the reset numerator; typed rows are obvious by hand
  stim_row_t reset_rows [13] = '{
    '{10'd0,    1'b1, '{1'b1, 14'd5000, 4'd5, 4'd0, 4'd0}},
    '{10'd1,    1'b1, '{1'b0, 14'd9999, 4'd9, 4'd9, 4'd9}},
    '{10'd0,    1'b1, '{1'b1, 14'd9999, 4'd9, 4'd9, 4'd9}},
    '{10'd1023, 1'b0, '0},
    '{10'd512,  1'b0, '0},
    '{10'd221,  1'b0, '0},
    '{10'h2AA,  1'b0, '0},
    '{10'h155,  1'b0, '0},
    '{10'd1022, 1'b0, '0},
    '{10'd2,    1'b0, '0},
    '{10'd767,  1'b0, '0},
    '{10'd256,  1'b0, '0},
    '{10'd0,    1'b0, '0}
  };

  // Readings with a zero numerator: quotient is zero, only the zero sample flags an error
  logic [SAMPLE_W-1:0] zero_num_samples [4] = '{10'd1, 10'd1023, 10'd0, 10'd300};

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Advance the filter by one reading and form the displayed word
  function automatic reading_t predict_reading(input logic [SAMPLE_W-1:0] sample);
    reading_t         r;
    logic [ACC_W:0]   next_acc;
    logic [ACC_W-1:0] quotient;
    logic [ACC_W-1:0] avg;
    mv_t              shown;
    r.divide_error = (sample == '0);
    if (!r.divide_error) begin
      quotient = ACC_W'(numerator) / ACC_W'(sample);
      next_acc = {1'b0, filtered_acc} - {1'b0, filtered_acc >> SHIFT} + {1'b0, quotient};
      if (next_acc > {1'b0, ACC_MAX}) begin
        next_acc = {1'b0, ACC_MAX};
      end
      filtered_acc = next_acc[ACC_W-1:0];
    end
    avg = filtered_acc >> SHIFT;
    shown = (avg > ACC_W'(SHOW_MAX)) ? SHOW_MAX : avg[MV_W-1:0];
    r.supply_mv        = shown;
    r.volts_digit      = DIGIT_W'(shown / 1000);
    r.tenths_digit     = DIGIT_W'((shown % 1000) / 100);
    r.hundredths_digit = DIGIT_W'((shown % 100) / 10);
    return r;
  endfunction

  // Offer one sample word, hold it until taken, then queue its reading
  task automatic send_sample(input logic [SAMPLE_W-1:0] sample, input bit typed,
                             input reading_t typed_result);
    reading_t r;
    if (!no_idle && $urandom_range(0, 99) < 20) begin
      in_if.valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(negedge clk);
    end
    in_if.valid      <= 1'b1;
    in_if.raw_sample <= sample;
    do @(posedge clk); while (!in_if.ready);
    r = predict_reading(sample);
    pending_readings.push_back(typed ? typed_result : r);
    @(negedge clk);
  endtask

  // Drop valid and hold until every queued reading has come back
  task automatic drain;
    if (pending_readings.size() != 0) begin
      in_if.valid <= 1'b0;
      while (pending_readings.size() != 0) @(negedge clk);
    end
  endtask

  // Write the numerator while the block is idle
  task automatic set_numerator(input logic [NUM_W-1:0] value);
    drain();
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= value;
    @(negedge clk);
    cfg_wr_en   <= 1'b0;
    numerator = value;
  endtask

  task automatic check_field(input string name, input logic [15:0] want,
                             input logic [15:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
      fail_count++;
    end
  endtask

  // Hold ready low at random, except during the full-rate stretch
  always @(negedge clk) begin
    out_if.ready <= no_idle || ($urandom_range(0, 99) >= 20);
  end

  // Compare each taken result word with the oldest queued reading
  always @(posedge clk) begin : result_check
    reading_t want;
    if (rst_n && out_if.valid && out_if.ready) begin
      if (pending_readings.size() == 0) begin
        $display("%0t: result word with nothing queued, actual mv %0d err %0b",
                 $time, out_if.supply_mv, out_if.divide_error);
        fail_count++;
      end else begin
        want = pending_readings.pop_front();
        check_field("divide_error", 16'(want.divide_error),
                    16'(out_if.divide_error));
        check_field("supply_mv", 16'(want.supply_mv), 16'(out_if.supply_mv));
        check_field("volts_digit", 16'(want.volts_digit), 16'(out_if.volts_digit));
        check_field("tenths_digit", 16'(want.tenths_digit),
                    16'(out_if.tenths_digit));
        check_field("hundredths_digit", 16'(want.hundredths_digit),
                    16'(out_if.hundredths_digit));
      end
    end
  end

  initial begin : stimulus
    logic [NUM_W-1:0]    phase_num [RANDOM_PHASES];
    logic [SAMPLE_W-1:0] sample;
    int unsigned         pick;
    in_if.valid      = 1'b0;
    in_if.raw_sample = '0;
    out_if.ready     = 1'b0;
    cfg_wr_en        = 1'b0;
    cfg_wr_data      = '0;
    rst_n            = 1'b0;
    numerator        = NUM_RESET;
    filtered_acc     = ACC_W'(START_MV << SHIFT);
    repeat (9) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed: reset numerator
    foreach (reset_rows[i]) begin
      send_sample(reset_rows[i].sample, reset_rows[i].typed, reset_rows[i].result);
    end

    // Directed: zero numerator
    set_numerator(NUM_ZERO);
    foreach (zero_num_samples[i]) begin
      send_sample(zero_num_samples[i], 1'b0, '0);
    end

    // Directed: largest numerator against the smallest and largest reading
    set_numerator(NUM_MAX);
    send_sample(10'd1, 1'b0, '0);
    send_sample(10'd1023, 1'b0, '0);

    // Random phases across several numerator settings
    phase_num[0] = NUM_MAX;
    phase_num[1] = NUM_W'(1);
    phase_num[2] = NUM_W'($urandom_range(1, 2097151));
    phase_num[3] = NUM_RESET;
    phase_num[4] = NUM_W'($urandom_range(900000, 1300000));
    for (int p = 0; p < RANDOM_PHASES; p++) begin
      set_numerator(phase_num[p]);
      no_idle = (p == FULL_RATE_PHASE);
      for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
        pick = $urandom_range(0, 99);
        if (pick < 10) begin
          sample = '0;
        end else if (pick < 30) begin
          sample = SAMPLE_W'($urandom_range(0, 1023));
        end else begin
          sample = SAMPLE_W'($urandom_range(150, 400));
        end
        if (!no_idle && $urandom_range(0, 49) == 0) begin
          drain();
        end
        send_sample(sample, 1'b0, '0);
      end
      no_idle = 1'b0;
    end

    drain();
    repeat (SETTLE_CYCLES) @(negedge clk);
    if (fail_count == 0) begin
      $display("supply_voltage_monitor_tb passed");
    end else begin
      $display("supply_voltage_monitor_tb failed");
    end
    $finish;
  end

  // Stop a hung run
  initial begin
    #2_000_000;
    $display("supply_voltage_monitor_tb failed");
    $finish;
  end

endmodule
